// File: hw/rtl/csort_pkg.sv
// csort_pkg: types, sizes and codes shared by the counting sort engine
// no dependencies; used by csort_front, csort_back and counting_sort_engine_unit

package csort_pkg;

	localparam int NUM_BINS    = 256;
	localparam int COUNT_WIDTH = 16;

	localparam int KEY_W     = 8;
	localparam int KEY_SPAN  = 1 << KEY_W;
	localparam int BIN_DEPTH = (NUM_BINS < KEY_SPAN) ? NUM_BINS : KEY_SPAN;
	localparam int BIN_W     = $clog2(BIN_DEPTH);
	localparam int IDX_W     = BIN_W + 1;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key_in;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_out;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic             pop;
		logic             drop;
		logic [BIN_W-1:0] bin;
	} job_t;

endpackage

// File: hw/rtl/csort_front.sv
// csort_front: accepts request transfers, classifies them and queues them
// depends on csort_pkg

module csort_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  csort_pkg::req_t   req,
	output logic              job_valid,
	input  logic              job_take,
	output csort_pkg::job_t   job
);

	csort_pkg::job_t                  q_mem_q [csort_pkg::Q_DEPTH];
	logic [csort_pkg::Q_AW-1:0]       wr_ptr_q;
	logic [csort_pkg::Q_AW-1:0]       rd_ptr_q;
	logic [csort_pkg::Q_CW-1:0]       fill_q;
	csort_pkg::job_t                  job_in;
	logic                             push;
	logic                             pull;

	always_comb begin
		job_in.pop  = (req.cmd == csort_pkg::CMD_POP);
		job_in.drop = (req.cmd == csort_pkg::CMD_INSERT) &&
			({1'b0, req.key_in} >= (csort_pkg::KEY_W + 1)'(csort_pkg::BIN_DEPTH));
		job_in.bin  = req.key_in[csort_pkg::BIN_W-1:0];
	end

	assign req_stall = (fill_q == csort_pkg::Q_CW'(csort_pkg::Q_DEPTH));
	assign push      = req_valid && !req_stall;
	assign job_valid = (fill_q != '0);
	assign pull      = job_valid && job_take;
	assign job       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == csort_pkg::Q_AW'(csort_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pull) begin
				rd_ptr_q <= (rd_ptr_q == csort_pkg::Q_AW'(csort_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pull) begin
				fill_q <= fill_q + 1'b1;
			end else if (pull && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/csort_back.sv
// csort_back: bin count memory, occupancy bits, upward scan and result register
// depends on csort_pkg

module csort_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_take,
	input  csort_pkg::job_t   job,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output csort_pkg::rsp_t   rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_POP  = 2'd3;

	localparam int BD = csort_pkg::BIN_DEPTH;
	localparam int BW = csort_pkg::BIN_W;
	localparam int CW = csort_pkg::COUNT_WIDTH;

	logic [CW-1:0]                  mem [BD];
	logic [CW-1:0]                  rd_q;
	logic [BD-1:0]                  occ_q;
	logic [BW-1:0]                  ptr_q;
	logic [BW-1:0]                  bin_q;
	logic [csort_pkg::IDX_W-1:0]    idx_q;
	logic [1:0]                     state_q;
	logic                           rsp_valid_q;
	csort_pkg::rsp_t                rsp_q;

	logic                           can_start;
	logic                           rd_en;
	logic [BW-1:0]                  rd_addr;
	logic                           wr_en;
	logic [CW-1:0]                  wr_data;
	logic [CW-1:0]                  cnt;
	logic                           rsp_set;
	csort_pkg::rsp_t                rsp_next;
	logic [BD-1:0]                  below_ptr;

	assign can_start = !rsp_valid_q || !rsp_stall;
	assign job_take  = (state_q == S_IDLE) && job_valid && can_start;
	assign cnt       = occ_q[bin_q] ? rd_q : '0;
	assign below_ptr = (BD'(1) << ptr_q) - BD'(1);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		rd_en            = 1'b0;
		rd_addr          = job.pop ? ptr_q : job.bin;
		wr_en            = 1'b0;
		wr_data          = cnt + CW'(1);
		rsp_set          = 1'b0;
		rsp_next.key_out = '0;
		rsp_next.status  = csort_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (job_take) begin
					if (job.pop) begin
						rd_en = occ_q[ptr_q];
					end else if (job.drop) begin
						rsp_set         = 1'b1;
						rsp_next.status = csort_pkg::ST_DROPPED;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_INS: begin
				rsp_set = 1'b1;
				if (cnt == '1) begin
					rsp_next.status = csort_pkg::ST_DROPPED;
				end else begin
					wr_en = 1'b1;
				end
			end
			S_SCAN: begin
				rd_addr = idx_q[BW-1:0];
				if (idx_q == csort_pkg::IDX_W'(BD)) begin
					rsp_set         = 1'b1;
					rsp_next.status = csort_pkg::ST_EMPTY;
				end else begin
					rd_en = occ_q[idx_q[BW-1:0]];
				end
			end
			S_POP: begin
				wr_en            = 1'b1;
				wr_data          = cnt - CW'(1);
				rsp_set          = 1'b1;
				rsp_next.key_out = csort_pkg::KEY_W'(bin_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[bin_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (rsp_set) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			ptr_q       <= '0;
			bin_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_take) begin
						if (job.pop) begin
							if (occ_q[ptr_q]) begin
								bin_q   <= ptr_q;
								state_q <= S_POP;
							end else begin
								idx_q   <= {1'b0, ptr_q} + csort_pkg::IDX_W'(1);
								state_q <= S_SCAN;
							end
						end else if (!job.drop) begin
							bin_q   <= job.bin;
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					if (cnt != '1) begin
						occ_q[bin_q] <= 1'b1;
						if (bin_q < ptr_q) begin
							ptr_q <= bin_q;
						end
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (idx_q == csort_pkg::IDX_W'(BD)) begin
						state_q <= S_IDLE;
					end else if (occ_q[idx_q[BW-1:0]]) begin
						bin_q   <= idx_q[BW-1:0];
						state_q <= S_POP;
					end else begin
						idx_q <= idx_q + csort_pkg::IDX_W'(1);
					end
				end
				S_POP: begin
					if (cnt == CW'(1)) begin
						occ_q[bin_q] <= 1'b0;
					end
					ptr_q   <= bin_q;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_below_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q & below_ptr) == '0)
		else $error("occupied bin below scan pointer");

	a_pop_bin_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> occ_q[bin_q])
		else $error("pop on an empty bin");

	a_busy_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !rsp_valid_q)
		else $error("result register held while an item is in progress");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= csort_pkg::IDX_W'(BD)))
		else $error("scan index beyond bin range");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(job_take && job.pop && !occ_q[ptr_q]) |=> (idx_q > {1'b0, ptr_q}))
		else $error("scan started at or below the pointer");
`endif

endmodule

// File: hw/rtl/counting_sort_engine_unit.sv
// counting_sort_engine_unit: top level of the counting sort engine
// depends on csort_pkg, csort_front, csort_back
//
// channel   handshake               payload                     dir
// req       req_valid / req_stall   req.cmd, req.key_in         in
// rsp       rsp_valid / rsp_stall   rsp.key_out, rsp.status     out
//
// an insert does one memory read, then the write back of the bin count unless saturated
// a pop reads the bin at the pointer, or first steps the upward scan over empty bins,
// then writes back the count less one; a pop that finds every bin empty scans from the
// pointer up to the last bin; each request waits in the 2-entry queue first; the queue
// keeps taking requests while the bin unit is busy or rsp stalls, until it is full
// reset clears the occupancy bits at once, so no clearing pass is needed

module counting_sort_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  csort_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output csort_pkg::rsp_t   rsp
);

	logic            job_valid;
	logic            job_take;
	csort_pkg::job_t job;

	csort_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	csort_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
